/* sv/gbnms_pkg.sv */
`timescale 1ns / 1ps
package gbnms_pkg;

  localparam int unsigned LIMIT_W   = 17;
  localparam int unsigned OFFS_W    = 5;
  localparam int unsigned MAXK_W    = 7;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned CLASS_W   = 8;
  localparam int unsigned BATCH_W   = 4;
  localparam int unsigned TAG_W     = CLASS_W + BATCH_W;
  localparam int unsigned KEPT_W    = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = LIMIT_W;
  localparam int unsigned EMIT_W    = 7;
  localparam int unsigned RESULT_CAP = 64;
  localparam int unsigned FRAC_SHIFT = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IOU_LIMIT = 2'd0,
    REG_COORD_OFFSET = 2'd1,
    REG_MAX_KEPT = 2'd2,
    REG_GROUP_MODE = 2'd3
  } cfg_reg_t;

  localparam logic [MODE_W-1:0] MODE_ALL   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BATCH = 2'd1;

  typedef enum logic [15:0] {
    ST_LOAD   = 16'h0001,
    ST_SORT_A = 16'h0002,
    ST_SORT_B = 16'h0004,
    ST_SORT_C = 16'h0008,
    ST_SORT_D = 16'h0010,
    ST_W_S    = 16'h0020,
    ST_W_SEL  = 16'h0040,
    ST_W_SELD = 16'h0080,
    ST_W_PUSH = 16'h0100,
    ST_W_T    = 16'h0200,
    ST_W_TC   = 16'h0400,
    ST_W_TD   = 16'h0800,
    ST_W_M1   = 16'h1000,
    ST_W_M2   = 16'h2000,
    ST_W_M3   = 16'h4000,
    ST_FIN    = 16'h8000
  } state_t;

endpackage

/* sv/gbnms_ram.sv */
`timescale 1ns / 1ps
module gbnms_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* sv/grouped_box_nms.sv */
`timescale 1ns / 1ps
// Load: one box per cycle while s_axis_tready is high, in the load state only. Processing
// after the closing box: rank the n boxes by score (one score memory read per cycle), then
// for each pair of a kept box and a live later box in its group run the serial span,
// multiply, union and compare steps. Each result waits for the single output register to
// drain. rst is synchronous: clears control state, the set counters and the config
// registers; the box memories hold no reset and are defined once written.
module grouped_box_nms #(
  parameter int unsigned MAX_BOXES   = 64,
  parameter int unsigned MAX_BATCHES = 16,
  parameter int unsigned COORD_BITS  = 16,
  parameter int unsigned SCORE_BITS  = 16
) (
  input  logic clk,
  input  logic rst,
  // config write port
  input  logic                                cfg_we,
  input  logic [gbnms_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gbnms_pkg::CFG_W-1:0]         cfg_data,
  // box input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata, low bit up: box_left, box_top, box_right, box_bottom, box_score, class_tag, zero pad
  input  logic [((4*COORD_BITS+SCORE_BITS+gbnms_pkg::CLASS_W+7)/8)*8-1:0] s_axis_tdata,
  // tuser: batch_tag
  input  logic [gbnms_pkg::BATCH_W-1:0]       s_axis_tuser,
  input  logic                                s_axis_tlast,
  // kept index stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata, low bit up: kept_index, zero pad
  output logic [7:0]                          m_axis_tdata,
  // tuser: overflowed
  output logic [0:0]                          m_axis_tuser,
  output logic                                m_axis_tlast
);
  import gbnms_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_BOXES);
  localparam int unsigned CNT_W  = $clog2(MAX_BOXES + 1);
  localparam int unsigned BSEL_W = (MAX_BATCHES > 1) ? $clog2(MAX_BATCHES) : 1;
  localparam int unsigned CRN_W  = 4 * COORD_BITS;
  localparam int unsigned DIF_W  = COORD_BITS + 2;
  localparam int unsigned SPAN_W = COORD_BITS + 1;
  localparam int unsigned AREA_W = 2 * SPAN_W;
  localparam int unsigned SUM_W  = AREA_W + 1;
  localparam int unsigned PROD_W = SUM_W + LIMIT_W;
  localparam int unsigned SCO_LO = CRN_W;
  localparam int unsigned CLS_LO = CRN_W + SCORE_BITS;

  // config registers
  logic [LIMIT_W-1:0] iou_limit;
  logic [OFFS_W-1:0]  coord_offset;
  logic [MAXK_W-1:0]  max_kept;
  logic [MODE_W-1:0]  group_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      iou_limit    <= LIMIT_W'(32768);
      coord_offset <= '0;
      max_kept     <= '0;
      group_mode   <= MODE_ALL;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IOU_LIMIT:    iou_limit    <= cfg_data;
        REG_COORD_OFFSET: coord_offset <= cfg_data[OFFS_W-1:0];
        REG_MAX_KEPT:     max_kept     <= cfg_data[MAXK_W-1:0];
        REG_GROUP_MODE:   group_mode   <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // batch tag folded into the counter range, built at elaboration
  logic [BSEL_W-1:0] bmod [2**BATCH_W];
  for (genvar g = 0; g < 2**BATCH_W; g++) begin : g_bmod
    localparam int unsigned BM = g % MAX_BATCHES;
    assign bmod[g] = BSEL_W'(BM);
  end

  function automatic logic [SPAN_W-1:0] span_f(input logic signed [COORD_BITS-1:0] lo,
                                               input logic signed [COORD_BITS-1:0] hi,
                                               input logic [OFFS_W-1:0] off);
    logic signed [DIF_W-1:0] d;
    d = DIF_W'(hi) - DIF_W'(lo) + $signed({1'b0, (DIF_W-1)'(off)});
    return (d > 0) ? d[SPAN_W-1:0] : '0;
  endfunction

  function automatic logic [KEPT_W-1:0] kept_f(input logic [IDX_W-1:0] v);
    logic [IDX_W+KEPT_W-1:0] e;
    e = (IDX_W+KEPT_W)'(v);
    return e[KEPT_W-1:0];
  endfunction

  // mode three behaves as mode two
  logic mode_any, mode_class;
  assign mode_any   = (group_mode != MODE_ALL);
  assign mode_class = (group_mode != MODE_ALL) && (group_mode != MODE_BATCH);

  state_t state;

  logic [CNT_W-1:0]  loaded;
  logic              drop;
  logic [IDX_W-1:0]  si, sj, rank;
  logic signed [SCORE_BITS-1:0] score_i;
  logic [CNT_W-1:0]  s, t;
  logic [IDX_W-1:0]  sel;
  logic [CRN_W-1:0]  sel_crn;
  logic [AREA_W-1:0] sel_area, cand_area;
  logic [TAG_W-1:0]  sel_tag;
  logic [SPAN_W-1:0] sx, sy;
  logic [AREA_W-1:0] inter;
  logic [SUM_W-1:0]  area_sum, uni;
  logic              uni_ok;
  logic [MAXK_W-1:0] bcnt [MAX_BATCHES];
  logic [CNT_W-1:0]  kept;
  logic [EMIT_W-1:0] emitted;
  logic              pend_valid, brk;
  logic [KEPT_W-1:0] pend_idx;

  // memories
  logic              ld_we;
  logic [IDX_W-1:0]  ld_addr;
  logic [CRN_W-1:0]  crn_rdata;
  logic [SCORE_BITS-1:0] sco_rdata;
  logic [TAG_W-1:0]  tag_rdata;
  logic [AREA_W-1:0] area_rdata, ld_area;
  logic [IDX_W-1:0]  ord_rdata, sco_raddr, ord_raddr;
  logic              ord_we;

  assign s_axis_tready = (state == ST_LOAD);
  assign ld_we   = s_axis_tvalid && s_axis_tready && (loaded < CNT_W'(MAX_BOXES));
  assign ld_addr = loaded[IDX_W-1:0];
  assign ld_area = AREA_W'(span_f(s_axis_tdata[COORD_BITS-1:0],
                                  s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS], coord_offset))
                 * AREA_W'(span_f(s_axis_tdata[2*COORD_BITS-1:COORD_BITS],
                                  s_axis_tdata[CRN_W-1:3*COORD_BITS], coord_offset));

  always_comb begin
    unique case (state)
      ST_SORT_A: sco_raddr = si;
      ST_SORT_B: sco_raddr = '0;
      default:   sco_raddr = sj + IDX_W'(1);
    endcase
  end
  assign ord_raddr = (state == ST_W_T) ? t[IDX_W-1:0] : s[IDX_W-1:0];
  assign ord_we    = (state == ST_SORT_D);

  gbnms_ram #(.WIDTH(CRN_W), .DEPTH(MAX_BOXES)) u_corner (
    .clk(clk), .we(ld_we), .waddr(ld_addr), .wdata(s_axis_tdata[CRN_W-1:0]),
    .raddr(ord_rdata), .rdata(crn_rdata));
  gbnms_ram #(.WIDTH(SCORE_BITS), .DEPTH(MAX_BOXES)) u_score (
    .clk(clk), .we(ld_we), .waddr(ld_addr), .wdata(s_axis_tdata[CLS_LO-1:SCO_LO]),
    .raddr(sco_raddr), .rdata(sco_rdata));
  gbnms_ram #(.WIDTH(TAG_W), .DEPTH(MAX_BOXES)) u_tag (
    .clk(clk), .we(ld_we), .waddr(ld_addr),
    .wdata({s_axis_tuser, s_axis_tdata[CLS_LO+CLASS_W-1:CLS_LO]}),
    .raddr(ord_rdata), .rdata(tag_rdata));
  gbnms_ram #(.WIDTH(AREA_W), .DEPTH(MAX_BOXES)) u_area (
    .clk(clk), .we(ld_we), .waddr(ld_addr), .wdata(ld_area),
    .raddr(ord_rdata), .rdata(area_rdata));
  gbnms_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BOXES)) u_order (
    .clk(clk), .we(ord_we), .waddr(rank), .wdata(si),
    .raddr(ord_raddr), .rdata(ord_rdata));

  // ranking compare: earlier index wins a tie
  logic rank_inc;
  assign rank_inc = ($signed(sco_rdata) > score_i) ||
                    (($signed(sco_rdata) == score_i) && (sj < si));

  // selected box checks
  logic [BSEL_W-1:0] bsel;
  logic              cap_full, brk_now;
  assign bsel     = bmod[tag_rdata[TAG_W-1:CLASS_W]];
  assign cap_full = mode_any && (max_kept != '0) && (bcnt[bsel] >= max_kept);
  assign brk_now  = !mode_any && (max_kept != '0) &&
                    ((kept + CNT_W'(1)) == CNT_W'(max_kept));

  // candidate overlap spans
  logic group_skip;
  logic signed [COORD_BITS-1:0] ca [4];
  logic signed [COORD_BITS-1:0] sa [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ca[k] = crn_rdata[k*COORD_BITS +: COORD_BITS];
      sa[k] = sel_crn[k*COORD_BITS +: COORD_BITS];
    end
  end
  assign group_skip = (mode_any && (sel_tag[TAG_W-1:CLASS_W] != tag_rdata[TAG_W-1:CLASS_W])) ||
                      (mode_class && (sel_tag[CLASS_W-1:0] != tag_rdata[CLASS_W-1:0]));

  logic [PROD_W-1:0] lhs, rhs;
  assign lhs = PROD_W'({inter, FRAC_SHIFT'(0)});
  assign rhs = PROD_W'(iou_limit) * PROD_W'(uni);

  // suppression marks by sorted position: clear each live entry while ranking,
  // set on a hit, read in the cycle after the walk addresses it
  logic             hit, supp_we, supp_wdata, supp_rdata;
  logic [IDX_W-1:0] supp_waddr;
  assign hit        = uni_ok && (lhs > rhs);
  assign supp_we    = (state == ST_SORT_D) || ((state == ST_W_M3) && hit);
  assign supp_waddr = (state == ST_SORT_D) ? si : t[IDX_W-1:0];
  assign supp_wdata = (state == ST_W_M3);

  gbnms_ram #(.WIDTH(1), .DEPTH(MAX_BOXES)) u_supp (
    .clk(clk), .we(supp_we), .waddr(supp_waddr), .wdata(supp_wdata),
    .raddr(ord_raddr), .rdata(supp_rdata));

  logic out_free, out_load;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign out_load = out_free && ((state == ST_W_PUSH) || ((state == ST_FIN) && pend_valid));

  // output register: load a pending transfer, else drain on ready
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      loaded        <= '0;
      drop          <= 1'b0;
      pend_valid    <= 1'b0;
      kept          <= '0;
      emitted       <= '0;
      brk           <= 1'b0;
      for (int b = 0; b < MAX_BATCHES; b++) bcnt[b] <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (s_axis_tvalid) begin
            if (ld_we) loaded <= loaded + CNT_W'(1);
            else drop <= 1'b1;
            if (s_axis_tlast) begin
              // clear per-set counts, then rank
              kept    <= '0;
              emitted <= '0;
              for (int b = 0; b < MAX_BATCHES; b++) bcnt[b] <= '0;
              si <= '0;
              state <= ST_SORT_A;
            end
          end
        end
        ST_SORT_A: begin
          state <= (loaded == '0) ? ST_FIN : ST_SORT_B;
        end
        ST_SORT_B: begin
          score_i <= $signed(sco_rdata);
          sj      <= '0;
          rank    <= '0;
          state   <= ST_SORT_C;
        end
        ST_SORT_C: begin
          if (rank_inc) rank <= rank + IDX_W'(1);
          if (CNT_W'(sj) == loaded - CNT_W'(1)) state <= ST_SORT_D;
          else sj <= sj + IDX_W'(1);
        end
        ST_SORT_D: begin
          // order memory takes si at rank this cycle
          si <= si + IDX_W'(1);
          if (CNT_W'(si) == loaded - CNT_W'(1)) begin
            s <= '0;
            state <= ST_W_S;
          end else begin
            state <= ST_SORT_A;
          end
        end
        ST_W_S: begin
          if (s == loaded) state <= ST_FIN;
          else state <= ST_W_SEL;
        end
        ST_W_SEL: begin
          if (supp_rdata) begin
            s <= s + CNT_W'(1);
            state <= ST_W_S;
          end else begin
            sel   <= ord_rdata;
            state <= ST_W_SELD;
          end
        end
        ST_W_SELD: begin
          sel_crn  <= crn_rdata;
          sel_area <= area_rdata;
          sel_tag  <= tag_rdata;
          t        <= s + CNT_W'(1);
          if (cap_full) begin
            s <= s + CNT_W'(1);
            state <= ST_W_S;
          end else begin
            kept <= kept + CNT_W'(1);
            if (mode_any) bcnt[bsel] <= bcnt[bsel] + MAXK_W'(1);
            brk <= brk_now;
            if (emitted < EMIT_W'(RESULT_CAP)) begin
              emitted <= emitted + EMIT_W'(1);
              if (pend_valid) begin
                state <= ST_W_PUSH;
              end else begin
                pend_valid <= 1'b1;
                pend_idx   <= kept_f(sel);
                state      <= brk_now ? ST_FIN : ST_W_T;
              end
            end else begin
              state <= brk_now ? ST_FIN : ST_W_T;
            end
          end
        end
        ST_W_PUSH: begin
          // hold until the output register frees
          if (out_free) begin
            m_axis_tdata  <= 8'(pend_idx);
            m_axis_tuser  <= drop;
            m_axis_tlast  <= 1'b0;
            pend_idx      <= kept_f(sel);
            state         <= brk ? ST_FIN : ST_W_T;
          end
        end
        ST_W_T: begin
          if (t == loaded) begin
            s <= s + CNT_W'(1);
            state <= ST_W_S;
          end else begin
            state <= ST_W_TC;
          end
        end
        ST_W_TC: begin
          // skip a candidate that is already suppressed
          if (supp_rdata) begin
            t <= t + CNT_W'(1);
            state <= ST_W_T;
          end else begin
            state <= ST_W_TD;
          end
        end
        ST_W_TD: begin
          if (group_skip) begin
            t <= t + CNT_W'(1);
            state <= ST_W_T;
          end else begin
            sx <= span_f((sa[0] > ca[0]) ? sa[0] : ca[0],
                         (sa[2] < ca[2]) ? sa[2] : ca[2], coord_offset);
            sy <= span_f((sa[1] > ca[1]) ? sa[1] : ca[1],
                         (sa[3] < ca[3]) ? sa[3] : ca[3], coord_offset);
            cand_area <= area_rdata;
            state <= ST_W_M1;
          end
        end
        ST_W_M1: begin
          inter    <= AREA_W'(sx) * AREA_W'(sy);
          area_sum <= SUM_W'(sel_area) + SUM_W'(cand_area);
          state    <= ST_W_M2;
        end
        ST_W_M2: begin
          // a non-positive union never suppresses
          uni_ok <= (area_sum > SUM_W'(inter));
          uni    <= area_sum - SUM_W'(inter);
          state  <= ST_W_M3;
        end
        ST_W_M3: begin
          t <= t + CNT_W'(1);
          state <= ST_W_T;
        end
        ST_FIN: begin
          if (!pend_valid || out_free) begin
            if (pend_valid) begin
              m_axis_tdata  <= 8'(pend_idx);
              m_axis_tuser  <= drop;
              m_axis_tlast  <= 1'b1;
            end
            pend_valid <= 1'b0;
            loaded     <= '0;
            drop       <= 1'b0;
            state      <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule

/* test/grouped_box_nms_test.sv */
`timescale 1ns / 1ps
module grouped_box_nms_test;
  import gbnms_pkg::*;

  localparam int NBOX = 64;
  localparam int WATCH_LIMIT = 400000;

  typedef struct {
    logic signed [15:0] left, top, right, bottom, score;
    logic [7:0] cls;
    logic [3:0] batch;
    logic       last;
  } box_t;

  typedef struct {
    logic [5:0] idx;
    logic       last;
    logic       ovf;
  } kept_t;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic [3:0] s_axis_tuser = '0;
  logic s_axis_tlast = 0;
  logic m_axis_tvalid, m_axis_tready = 0, m_axis_tlast;
  logic [7:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;

  grouped_box_nms dut (.*);

  initial forever #6 clk = ~clk;

  // predictor copy of the configuration and the box store
  logic [16:0] iou_lim = 17'd32768;
  logic [4:0]  offs = '0;
  logic [6:0]  kcap = '0;
  logic [1:0]  gmode = '0;
  box_t store[NBOX];
  int   n_loaded = 0;
  bit   dropped = 0;
  kept_t kept_q[$];

  int errors = 0, idle_cycles = 0;
  bit calm = 0;

  task automatic report(string what);
    $display("mismatch: %s at %0t", what, $realtime);
    errors++;
  endtask

  function automatic longint span(longint lo, longint hi);
    longint d = hi - lo + offs;
    return d > 0 ? d : 0;
  endfunction

  function automatic longint area_of(box_t b);
    return span(b.left, b.right) * span(b.top, b.bottom);
  endfunction

  function automatic bit overlap_hit(box_t a, box_t b);
    longint x1, y1, x2, y2, ov, sum;
    x1 = a.left > b.left ? a.left : b.left;
    y1 = a.top > b.top ? a.top : b.top;
    x2 = a.right < b.right ? a.right : b.right;
    y2 = a.bottom < b.bottom ? a.bottom : b.bottom;
    ov = span(x1, x2) * span(y1, y2);
    sum = area_of(a) + area_of(b);
    if (sum <= ov) return 0;
    return ov * 65536 > longint'(iou_lim) * (sum - ov);
  endfunction

  // greedy suppression over the loaded set; queue kept indices
  task automatic predict_set();
    int order[NBOX];
    bit gone[NBOX];
    int per_batch[16];
    int mode, kept, emitted, rank, sel, cand;
    mode = gmode >= 2 ? 2 : gmode;
    kept = 0; emitted = 0;
    for (int i = 0; i < 16; i++) per_batch[i] = 0;
    for (int i = 0; i < n_loaded; i++) begin
      gone[i] = 0;
      rank = 0;
      for (int j = 0; j < n_loaded; j++)
        if (store[j].score > store[i].score || (store[j].score == store[i].score && j < i))
          rank++;
      order[rank] = i;
    end
    for (int s = 0; s < n_loaded; s++) begin
      if (gone[s]) continue;
      sel = order[s];
      if (mode != 0 && kcap != 0 && per_batch[store[sel].batch] >= kcap) continue;
      if (emitted < RESULT_CAP) begin
        kept_q = {kept_q, kept_t'{idx: sel[5:0], last: 1'b0, ovf: dropped}};
        emitted++;
      end
      kept++;
      if (mode != 0) per_batch[store[sel].batch]++;
      else if (kcap != 0 && kept == kcap) break;
      for (int t = s + 1; t < n_loaded; t++) begin
        if (gone[t]) continue;
        cand = order[t];
        if (mode >= 1 && store[sel].batch != store[cand].batch) continue;
        if (mode == 2 && store[sel].cls != store[cand].cls) continue;
        if (overlap_hit(store[sel], store[cand])) gone[t] = 1;
      end
    end
    if (emitted > 0) kept_q[$].last = 1;
    n_loaded = 0;
    dropped = 0;
  endtask

  // drop tvalid for a random burst
  task automatic idle_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
  endtask

  // send one box and wait for its transfer; tvalid stays up for a following box
  task automatic send_box(box_t b);
    @(negedge clk);
    idle_gap();
    s_axis_tvalid <= 1;
    s_axis_tdata <= {b.cls, b.score, b.bottom, b.right, b.top, b.left};
    s_axis_tuser <= b.batch;
    s_axis_tlast <= b.last;
    do @(posedge clk); while (!s_axis_tready);
    if (n_loaded < NBOX) begin
      store[n_loaded] = b;
      n_loaded++;
    end else dropped = 1;
    if (b.last) predict_set();
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 0;
    while (kept_q.size() != 0) @(posedge clk);
    repeat (9000) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [16:0] v);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= r; cfg_data <= v;
    @(negedge clk);
    cfg_we <= 0;
    case (r)
      REG_IOU_LIMIT: iou_lim = v;
      REG_COORD_OFFSET: offs = v[4:0];
      REG_MAX_KEPT: kcap = v[6:0];
      default: gmode = v[1:0];
    endcase
  endtask

  task automatic set_config(logic [16:0] lim, logic [4:0] o, logic [6:0] k, logic [1:0] g);
    write_reg(REG_IOU_LIMIT, lim);
    write_reg(REG_COORD_OFFSET, 17'(o));
    write_reg(REG_MAX_KEPT, 17'(k));
    write_reg(REG_GROUP_MODE, 17'(g));
  endtask

  // clustered boxes so overlaps are common; few classes and batches
  function automatic box_t rand_box(bit last, bit wide);
    box_t b;
    int cx = int'($urandom_range(0, 600)) - 300, cy = int'($urandom_range(0, 600)) - 300;
    if (wide) begin
      b.left = 16'($urandom); b.top = 16'($urandom);
      b.right = 16'($urandom); b.bottom = 16'($urandom);
    end else begin
      b.left = 16'(cx - int'($urandom_range(0, 200)));
      b.top = 16'(cy - int'($urandom_range(0, 200)));
      b.right = 16'(cx + int'($urandom_range(0, 200)) - 20);
      b.bottom = 16'(cy + int'($urandom_range(0, 200)) - 20);
    end
    b.score = $urandom_range(0, 7) == 0 ? 16'sd1000 : 16'($urandom);
    b.cls = $urandom_range(0, 5) == 0 ? 8'($urandom) : 8'($urandom_range(0, 2));
    b.batch = $urandom_range(0, 5) == 0 ? 4'($urandom) : 4'($urandom_range(0, 2));
    b.last = last;
    return b;
  endfunction

  function automatic box_t mk(int l, int t, int r, int bo, int sc, int c, int ba, bit last);
    box_t b;
    b.left = 16'(l); b.top = 16'(t); b.right = 16'(r); b.bottom = 16'(bo);
    b.score = 16'(sc);
    b.cls = 8'(c); b.batch = 4'(ba); b.last = last;
    return b;
  endfunction

  // checker: compare each kept transfer with the oldest prediction
  always @(posedge clk) begin
    kept_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (kept_q.size() == 0) report("unexpected kept index");
      else begin
        e = kept_q.pop_front();
        if (m_axis_tdata != {2'b00, e.idx}) report("kept_index");
        if (m_axis_tlast != e.last) report("last_kept");
        if (m_axis_tuser[0] != e.ovf) report("overflowed");
      end
    end
  end

  // receiver stalls in random bursts
  initial begin
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
      m_axis_tready <= 1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  // watchdog: count cycles without any transfer
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // extremes of the fields, ties, degenerate boxes, lone box
  task automatic test_directed();
    send_box(mk(-32768, -32768, 32767, 32767, 32767, 255, 15, 0));
    send_box(mk(-32768, -32768, 32767, 32767, -32768, 0, 0, 0));
    send_box(mk(100, 100, 50, 50, 5, 1, 1, 0));
    send_box(mk(0, 0, 160, 160, 5, 1, 1, 0));
    send_box(mk(0, 0, 160, 160, 5, 1, 1, 0));
    send_box(mk(10, 10, 170, 170, 4, 2, 1, 1));
    drain();
    send_box(mk(0, 0, 0, 0, 0, 0, 0, 1));
    drain();
    set_config(17'd0, 5'd16, 7'd1, 2'd1);
    for (int i = 0; i < 6; i++) send_box(mk(i * 8, 0, i * 8 + 64, 64, i, i % 2, i % 2, i == 5));
    drain();
    set_config(17'd65536, 5'd31, 7'd64, 2'd3);
    for (int i = 0; i < 5; i++) send_box(mk(0, 0, 16, 16, i, 0, 0, i == 4));
    drain();
    set_config(17'h1ffff, 5'd0, 7'd127, 2'd2);
    for (int i = 0; i < 3; i++) send_box(mk(0, 0, 0, 0, 1, 0, 0, i == 2));
    drain();
  endtask

  // a set larger than the store: drop and overflow flag
  task automatic test_overflow();
    set_config(17'd16384, 5'd0, 7'd0, 2'd0);
    for (int i = 0; i < 67; i++) send_box(rand_box(i == 66, 0));
    drain();
  endtask

  // random sets under random settings
  task automatic test_random();
    int sent = 0, sz;
    while (sent < 170) begin
      if ($urandom_range(0, 1) == 0)
        set_config($urandom_range(0, 3) == 0 ? 17'($urandom) : 17'($urandom_range(0, 65536)),
                   5'($urandom), 7'($urandom_range(0, 4)), 2'($urandom));
      if (sent > 130) calm = 1;
      sz = $urandom_range(1, 12);
      for (int i = 0; i < sz; i++) send_box(rand_box(i == sz - 1, $urandom_range(0, 7) == 0));
      sent += sz;
      drain();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_directed();
    test_overflow();
    test_random();
    if (errors == 0 && kept_q.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* files.f */
sv/gbnms_pkg.sv
sv/gbnms_ram.sv
sv/grouped_box_nms.sv
test/grouped_box_nms_test.sv
